FILE: design/iwc_pkg.sv
// Shared constants and types for the intensity weighted centroid block.
package iwc_pkg;
  localparam int unsigned IndexBitsDef = 22;
  localparam int unsigned FracBitsDef  = 8;
  localparam int unsigned PixelBitsDef = 8;
  localparam int unsigned WidthBits    = 13;
  localparam int unsigned SumBits      = 52;
  localparam int unsigned IsumBits     = 30;
  localparam int unsigned CoordBits    = 30;
  localparam logic [WidthBits-1:0] WidthReset = 13'd640;
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrBits     = 2;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH = 1'b0
  } reg_idx_t;

  // Item passed from front to back part.
  typedef struct packed {
    logic [25:0] idx;
    logic [15:0] val;
    logic        last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_ACC,
    ST_DIVX,
    ST_DIVY,
    ST_EMIT
  } back_state_t;
endpackage

FILE: design/intensity_weighted_centroid_top.sv
// Top level of the intensity weighted centroid block.
// Usage:
//   Drive start with a pixel (index, value, last flag); it transfers when
//   busy is low. Pixels enter a four-deep queue; the back part drains it.
//   In the back part each pixel's index is split bit-serially into row and
//   column (skipped if the width register is zero). On a last pixel the two
//   coordinates go through one shared restoring divider (skipped if the
//   intensity sum is zero, which sets status), then out_valid pulses for
//   one cycle with centroid x, y and status. The receiver cannot stall; the
//   result is shown once. Reset clears the sums and the queue and sets the
//   image width to 640. The width register sits at address 0 of the APB
//   port; write it only while the block is idle (not enforced by the block).
module intensity_weighted_centroid_top #(
  parameter int unsigned INDEX_BITS = iwc_pkg::IndexBitsDef,
  parameter int unsigned FRAC_BITS  = iwc_pkg::FracBitsDef,
  parameter int unsigned PIXEL_BITS = iwc_pkg::PixelBitsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [INDEX_BITS-1:0]           in_pixel_index,
  input  logic [PIXEL_BITS-1:0]           in_pixel_value,
  input  logic                            in_last_pixel,
  output logic                            out_valid,
  output logic [iwc_pkg::CoordBits-1:0]   out_centroid_x,
  output logic [iwc_pkg::CoordBits-1:0]   out_centroid_y,
  output logic                            out_status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [1:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import iwc_pkg::*;

  logic [WidthBits-1:0] width_r, width_nxt;
  logic                 pop, q_valid;
  item_t                q_item;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == '0);
  assign prdata = (paddr == '0) ? 32'(width_r) : '0;
  assign width_nxt = wr_en ? pwdata[WidthBits-1:0] : width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) width_r <= WidthReset;
    else width_r <= width_nxt;
  end

  iwc_front #(.INDEX_BITS(INDEX_BITS), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk, .rst_n, .start, .in_pixel_index, .in_pixel_value, .in_last_pixel,
    .busy, .pop, .q_valid, .q_item
  );

  iwc_back #(.INDEX_BITS(INDEX_BITS), .FRAC_BITS(FRAC_BITS),
             .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk, .rst_n, .image_width(width_r), .q_valid, .q_item, .pop,
    .out_valid, .out_centroid_x, .out_centroid_y, .out_status
  );

`ifndef SYNTH
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_centroid_x == '0 && out_centroid_y == '0)
    else $error("error result carries nonzero coordinates");
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result shown twice");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");
`endif
endmodule

FILE: design/iwc_front.sv
// Front part: takes pixel transfers and queues them for the back part.
module iwc_front #(
  parameter int unsigned INDEX_BITS = iwc_pkg::IndexBitsDef,
  parameter int unsigned PIXEL_BITS = iwc_pkg::PixelBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [INDEX_BITS-1:0] in_pixel_index,
  input  logic [PIXEL_BITS-1:0] in_pixel_value,
  input  logic                  in_last_pixel,
  output logic                  busy,
  input  logic                  pop,
  output logic                  q_valid,
  output iwc_pkg::item_t        q_item
);
  import iwc_pkg::*;

  item_t              q_mem_r [QDepth];
  logic [QPtrBits-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPtrBits:0]   cnt_r, cnt_nxt;
  logic                push;
  item_t               new_item;

  assign busy    = (cnt_r == (QPtrBits+1)'(QDepth));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

  always_comb begin
    new_item      = '0;
    new_item.idx  = 26'(in_pixel_index);
    new_item.val  = 16'(in_pixel_value);
    new_item.last = in_last_pixel;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPtrBits+1)'(push) - (QPtrBits+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= new_item;
  end
endmodule

FILE: design/iwc_back.sv
// Back part: splits index, accumulates sums, divides on the last pixel.
module iwc_back #(
  parameter int unsigned INDEX_BITS = iwc_pkg::IndexBitsDef,
  parameter int unsigned FRAC_BITS  = iwc_pkg::FracBitsDef,
  parameter int unsigned PIXEL_BITS = iwc_pkg::PixelBitsDef
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [iwc_pkg::WidthBits-1:0]        image_width,
  input  logic                                 q_valid,
  input  iwc_pkg::item_t                       q_item,
  output logic                                 pop,
  output logic                                 out_valid,
  output logic [iwc_pkg::CoordBits-1:0]        out_centroid_x,
  output logic [iwc_pkg::CoordBits-1:0]        out_centroid_y,
  output logic                                 out_status
);
  import iwc_pkg::*;

  localparam int unsigned CntBits = 7;
  // Quotient bits needed: sum bits plus fraction bits.
  localparam int unsigned DivSteps = SumBits + FRAC_BITS;
  localparam int unsigned NumBits  = SumBits + FRAC_BITS;
  // Row index restoring division over INDEX_BITS steps.
  localparam int unsigned TrialBits = ((INDEX_BITS > WidthBits) ? INDEX_BITS : WidthBits) + 1;
  localparam logic [CoordBits-1:0] CoordMax = '1;

  back_state_t state_r, state_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [INDEX_BITS-1:0] rem_r, rem_nxt;
  logic [PIXEL_BITS-1:0] val_r, val_nxt;
  logic                  last_r, last_nxt;
  logic [CntBits-1:0]    cnt_r, cnt_nxt;
  logic [SumBits-1:0]    csum_r, csum_nxt, rsum_r, rsum_nxt;
  logic [IsumBits-1:0]   isum_r, isum_nxt;
  logic [NumBits-1:0]    num_r, num_nxt;
  logic [IsumBits:0]     drem_r, drem_nxt;
  logic [CoordBits-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic                  sat_r, sat_nxt;
  logic                  stat_r, stat_nxt;
  logic                  valid_r, valid_nxt;

  logic [TrialBits-1:0]  trial;
  logic [IsumBits+1:0]   dtrial;
  logic [IsumBits:0]     dshift;
  logic                  qbit;
  logic [INDEX_BITS+PIXEL_BITS-1:0] cprod, rprod;
  logic [SumBits:0]      csum_add, rsum_add;
  logic [IsumBits:0]     isum_add;
  logic [CoordBits-1:0]  hold;
  logic [CoordBits-1:0]  qnew;

  assign out_valid      = valid_r;
  assign out_centroid_x = cx_r;
  assign out_centroid_y = cy_r;
  assign out_status     = stat_r;

  // one restoring step of index / width; quotient bits go into idx_r
  always_comb begin
    trial = TrialBits'({rem_r, idx_r[INDEX_BITS-1]}) - TrialBits'(image_width);
  end

  // one restoring step of num / isum
  always_comb begin
    dshift = {drem_r[IsumBits-1:0], num_r[NumBits-1]};
    dtrial = {1'b0, dshift} - (IsumBits+2)'(isum_r);
    qbit   = !dtrial[IsumBits+1];
  end

  always_comb begin
    cprod    = INDEX_BITS'(rem_r) * val_r;
    rprod    = idx_r * val_r;
    csum_add = {1'b0, csum_r} + (SumBits+1)'(cprod);
    rsum_add = {1'b0, rsum_r} + (SumBits+1)'(rprod);
    isum_add = {1'b0, isum_r} + (IsumBits+1)'(val_r);
    hold     = (state_r == ST_DIVX) ? cx_r : cy_r;
    qnew     = {hold[CoordBits-2:0], qbit};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = (image_width == '0) ? ST_ACC : ST_SPLIT;
      ST_SPLIT: if (cnt_r == CntBits'(INDEX_BITS-1)) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = !last_r ? ST_IDLE : (isum_add == '0 ? ST_EMIT : ST_DIVX);
      ST_DIVX:  if (cnt_r == CntBits'(DivSteps-1)) state_nxt = ST_DIVY;
      ST_DIVY:  if (cnt_r == CntBits'(DivSteps-1)) state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    idx_nxt = idx_r; rem_nxt = rem_r; val_nxt = val_r; last_nxt = last_r;
    cnt_nxt = cnt_r; csum_nxt = csum_r; rsum_nxt = rsum_r; isum_nxt = isum_r;
    num_nxt = num_r; drem_nxt = drem_r; cx_nxt = cx_r; cy_nxt = cy_r;
    sat_nxt = sat_r; stat_nxt = stat_r; valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          val_nxt  = PIXEL_BITS'(q_item.val);
          last_nxt = q_item.last;
          cnt_nxt  = '0;
          if (image_width == '0) begin
            rem_nxt = INDEX_BITS'(q_item.idx);   // column is whole index
            idx_nxt = '0;                        // row zero
          end else begin
            rem_nxt = '0;
            idx_nxt = INDEX_BITS'(q_item.idx);
          end
        end
      end
      ST_SPLIT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (!trial[TrialBits-1]) rem_nxt = trial[INDEX_BITS-1:0];
        else rem_nxt = {rem_r[INDEX_BITS-2:0], idx_r[INDEX_BITS-1]};
        idx_nxt = {idx_r[INDEX_BITS-2:0], !trial[TrialBits-1]};
      end
      ST_ACC: begin
        csum_nxt = csum_add[SumBits] ? '1 : csum_add[SumBits-1:0];
        rsum_nxt = rsum_add[SumBits] ? '1 : rsum_add[SumBits-1:0];
        isum_nxt = isum_add[IsumBits] ? '1 : isum_add[IsumBits-1:0];
        cnt_nxt  = '0;
        drem_nxt = '0;
        sat_nxt  = 1'b0;
        cx_nxt   = '0;
        cy_nxt   = '0;
        stat_nxt = 1'b0;
        num_nxt  = NumBits'(csum_nxt) << FRAC_BITS;
        if (last_r && isum_add == '0) stat_nxt = 1'b1;
        if (last_r) begin
          csum_nxt = '0;
          rsum_nxt = '0;
          // keep divisor; cleared after emit
          isum_nxt = isum_add[IsumBits] ? '1 : isum_add[IsumBits-1:0];
          num_nxt  = NumBits'(csum_add[SumBits] ? {SumBits{1'b1}} : csum_add[SumBits-1:0])
                     << FRAC_BITS;
          // row sum parked in rsum until DIVY
          rsum_nxt = rsum_add[SumBits] ? '1 : rsum_add[SumBits-1:0];
        end
      end
      ST_DIVX, ST_DIVY: begin
        cnt_nxt  = cnt_r + 1'b1;
        drem_nxt = qbit ? dtrial[IsumBits:0] : dshift;
        num_nxt  = {num_r[NumBits-2:0], 1'b0};
        // a set bit shifted out means the quotient does not fit
        if (hold[CoordBits-1]) sat_nxt = 1'b1;
        if (state_r == ST_DIVX) cx_nxt = qnew; else cy_nxt = qnew;
        if (cnt_r == CntBits'(DivSteps-1)) begin
          if (sat_nxt) begin
            if (state_r == ST_DIVX) cx_nxt = CoordMax; else cy_nxt = CoordMax;
          end
          cnt_nxt  = '0;
          drem_nxt = '0;
          sat_nxt  = 1'b0;
          num_nxt  = NumBits'(rsum_r) << FRAC_BITS;
        end
      end
      ST_EMIT: begin
        valid_nxt = 1'b1;
        isum_nxt  = '0;
        rsum_nxt  = '0;
        csum_nxt  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      csum_r  <= '0;
      rsum_r  <= '0;
      isum_r  <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      csum_r  <= csum_nxt;
      rsum_r  <= rsum_nxt;
      isum_r  <= isum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; rem_r <= rem_nxt; val_r <= val_nxt; last_r <= last_nxt;
    cnt_r <= cnt_nxt; num_r <= num_nxt; drem_r <= drem_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; sat_r <= sat_nxt; stat_r <= stat_nxt;
  end
endmodule

FILE: tb/intensity_weighted_centroid_top_tb.sv
// Testbench for the centroid block: directed table, width 1 and 0 cases, random regions.
module intensity_weighted_centroid_top_tb;
  import iwc_pkg::*;

  localparam int unsigned IdxW  = IndexBitsDef;
  localparam int unsigned PixW  = PixelBitsDef;
  localparam int unsigned FracW = FracBitsDef;
  localparam logic [SumBits-1:0]   SumMax   = '1;
  localparam logic [IsumBits-1:0]  IsumMax  = '1;
  localparam logic [CoordBits-1:0] CoordMax = '1;
  // Generous drain time: queue of pixels plus two serial divides.
  localparam int DrainCycles = 4 * (IdxW + 4) + 2 * (SumBits + FracW + 4) + 20;

  typedef struct packed {
    logic [CoordBits-1:0] cx;
    logic [CoordBits-1:0] cy;
    logic                 st;
  } centroid_t;

  typedef struct {
    logic [IdxW-1:0] idx;
    logic [PixW-1:0] val;
    logic            last;
    logic            known;
    centroid_t       res;
  } pixel_row_t;

  logic clk, rst_n, start, busy;
  logic [IdxW-1:0] in_pixel_index;
  logic [PixW-1:0] in_pixel_value;
  logic in_last_pixel;
  logic out_valid, out_status;
  logic [CoordBits-1:0] out_centroid_x, out_centroid_y;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;

  intensity_weighted_centroid_top dut (
    .clk, .rst_n, .start, .busy, .in_pixel_index, .in_pixel_value, .in_last_pixel,
    .out_valid, .out_centroid_x, .out_centroid_y, .out_status,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor state.
  logic [WidthBits-1:0] width_q;
  logic [SumBits-1:0]   col_sum, row_sum;
  logic [IsumBits-1:0]  int_sum;
  centroid_t            centroid_q[$];
  int errors = 0, pixels = 0, regions = 0, widths = 0;

  function automatic logic [CoordBits-1:0] fix_div(logic [SumBits-1:0] num,
                                                   logic [IsumBits-1:0] den);
    logic [63:0] q, r, f;
    q = num / den;
    r = num % den;
    f = (r << FracW) / den;
    if (q > (CoordMax >> FracW)) return CoordMax;
    q = (q << FracW) + f;
    return (q > CoordMax) ? CoordMax : q[CoordBits-1:0];
  endfunction

  // Accumulate one pixel; returns 1 and the centroid on a last pixel.
  function automatic bit centroid_accumulate(logic [IdxW-1:0] idx, logic [PixW-1:0] val,
                                             logic last, output centroid_t res);
    logic [63:0] row, col, s;
    if (width_q == 0) begin
      row = 0;
      col = idx;
    end else begin
      row = idx / width_q;
      col = idx % width_q;
    end
    s = col_sum + col * val;
    col_sum = (s > SumMax) ? SumMax : s[SumBits-1:0];
    s = row_sum + row * val;
    row_sum = (s > SumMax) ? SumMax : s[SumBits-1:0];
    s = int_sum + val;
    int_sum = (s > IsumMax) ? IsumMax : s[IsumBits-1:0];
    res = '0;
    if (!last) return 0;
    if (int_sum == 0) res.st = 1'b1;
    else begin
      res.cx = fix_div(col_sum, int_sum);
      res.cy = fix_div(row_sum, int_sum);
    end
    col_sum = '0;
    row_sum = '0;
    int_sum = '0;
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("intensity_weighted_centroid_top_tb failed");
    $finish;
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (centroid_q.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        centroid_t e;
        e = centroid_q.pop_front();
        if (out_centroid_x !== e.cx) report_mismatch("centroid_x", out_centroid_x, e.cx);
        if (out_centroid_y !== e.cy) report_mismatch("centroid_y", out_centroid_y, e.cy);
        if (out_status !== e.st) report_mismatch("status", out_status, e.st);
        regions++;
      end
    end
  end

  task automatic write_width(logic [WidthBits-1:0] w);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 2'(REG_IMAGE_WIDTH) << 2;
    pwdata <= 32'(w);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    width_q = w;
    widths++;
    @(posedge clk);
    if (prdata !== 32'(w)) report_mismatch("width readback", prdata, 64'(w));
  endtask

  task automatic wait_drained();
    start <= 0;
    while (centroid_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  bit idle_on = 1;
  task automatic send_pixel(logic [IdxW-1:0] idx, logic [PixW-1:0] val, logic last,
                            logic known, centroid_t want);
    centroid_t res;
    if (idle_on) while ($urandom_range(99) < 18) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; in_pixel_index <= idx; in_pixel_value <= val; in_last_pixel <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (centroid_accumulate(idx, val, last, res)) begin
      if (known && res !== want) report_mismatch("table row", res, want);
      centroid_q.push_back(res);
    end
    pixels++;
  endtask

  task automatic send_region(int n, int bias);
    logic [IdxW-1:0] idx;
    logic [PixW-1:0] val;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: idx = '1;
        1: idx = IdxW'($urandom_range(64));
        default: idx = IdxW'($urandom);
      endcase
      case ($urandom_range(7))
        0: val = 0;
        1: val = '1;
        default: val = PixW'($urandom);
      endcase
      if (bias == 0) val = 0;
      send_pixel(idx, val, i == n - 1, 0, '0);
    end
  endtask

  pixel_row_t dir_rows[$];
  logic [WidthBits-1:0] width_plan[6] = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd7, 13'd640};

  initial begin
    rst_n = 0; start = 0; in_pixel_index = 0; in_pixel_value = 0; in_last_pixel = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    width_q = WidthReset; col_sum = 0; row_sum = 0; int_sum = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed table at reset width 640; known results are read off directly.
    dir_rows = '{
      '{22'd0, 8'd0, 1'b1, 1'b1, centroid_t'{30'd0, 30'd0, 1'b1}},       // zero intensity
      '{22'd0, 8'd255, 1'b1, 1'b1, centroid_t'{30'd0, 30'd0, 1'b0}},
      '{22'd641, 8'd1, 1'b1, 1'b1, centroid_t'{30'd256, 30'd256, 1'b0}},
      '{22'h3FFFFF, 8'd255, 1'b1, 1'b0, centroid_t'('0)},
      '{22'd0, 8'd1, 1'b0, 1'b0, centroid_t'('0)},                        // truncation
      '{22'd1, 8'd2, 1'b1, 1'b0, centroid_t'('0)},
      '{22'd639, 8'd0, 1'b0, 1'b0, centroid_t'('0)},
      '{22'd639, 8'd0, 1'b1, 1'b1, centroid_t'{30'd0, 30'd0, 1'b1}},
      '{22'h2AAAAA, 8'hAA, 1'b0, 1'b0, centroid_t'('0)},
      '{22'h155555, 8'h55, 1'b1, 1'b0, centroid_t'('0)}
    };
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].idx, dir_rows[i].val, dir_rows[i].last,
                 dir_rows[i].known, dir_rows[i].res);
    wait_drained();

    // Width 1 forces column 0; width 0 makes the whole index the column.
    write_width(13'd1);
    send_pixel(22'd5, 8'd3, 1'b1, 1'b1, centroid_t'{30'd0, 30'd1280, 1'b0});
    wait_drained();
    write_width(13'd0);
    send_pixel(22'd5, 8'd3, 1'b1, 1'b1, centroid_t'{30'd1280, 30'd0, 1'b0});
    // Largest column with width 0: top of the coordinate range.
    send_pixel(22'h3FFFFF, 8'd1, 1'b1, 1'b1, centroid_t'{30'h3FFFFF00, 30'd0, 1'b0});
    wait_drained();

    // Random regions over several widths; mostly short regions.
    foreach (width_plan[w]) begin
      write_width(width_plan[w]);
      idle_on = (w != 2);
      for (int r = 0; r < 20; r++)
        send_region($urandom_range(1, 8), $urandom_range(15));
      // Hold off until all results are in, then continue.
      wait_drained();
    end

    $display("Covered %0d pixels, %0d regions checked, %0d width writes.",
             pixels, regions, widths);
    if (errors == 0) $display("intensity_weighted_centroid_top_tb passed");
    else $display("intensity_weighted_centroid_top_tb failed");
    $finish;
  end
endmodule
